// ===== design/kuzn_pkg.sv =====
// ----------------------------------------------------------------------------
// kuzn_pkg
// Shared types, S-box tables and linear-layer constants for the 128-bit cipher.
// ----------------------------------------------------------------------------
package kuzn_pkg;

  localparam int unsigned KEY_WORDS = 4;

  // block kind carried in tuser
  localparam logic KIND_ENC = 1'b0;
  localparam logic KIND_DEC = 1'b1;

  typedef logic [15:0][7:0] kz_block_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXPAND,
    ST_RUN,
    ST_FLUSH
  } kz_state_e;

  typedef struct packed {
    logic       load;      // capture input beat
    logic       key_init;  // seed key schedule from the key registers
    logic       expand;    // one key-schedule Feistel step
    logic       step;      // one cipher round
    logic       out_load;  // move finished block to the output register
    logic [4:0] cnt;
  } kz_cmd_t;

  localparam logic [7:0] RED_POLY = 8'hC3;

  localparam logic [7:0] LIN_COEF [16] = '{
    8'h94, 8'h20, 8'h85, 8'h10, 8'hC2, 8'hC0, 8'h01, 8'hFB,
    8'h01, 8'hC0, 8'hC2, 8'h10, 8'h85, 8'h20, 8'h94, 8'h01
  };

  localparam logic [7:0] SBOX_FWD [256] = '{
    8'hFC,8'hEE,8'hDD,8'h11,8'hCF,8'h6E,8'h31,8'h16,8'hFB,8'hC4,8'hFA,8'hDA,8'h23,8'hC5,8'h04,8'h4D,
    8'hE9,8'h77,8'hF0,8'hDB,8'h93,8'h2E,8'h99,8'hBA,8'h17,8'h36,8'hF1,8'hBB,8'h14,8'hCD,8'h5F,8'hC1,
    8'hF9,8'h18,8'h65,8'h5A,8'hE2,8'h5C,8'hEF,8'h21,8'h81,8'h1C,8'h3C,8'h42,8'h8B,8'h01,8'h8E,8'h4F,
    8'h05,8'h84,8'h02,8'hAE,8'hE3,8'h6A,8'h8F,8'hA0,8'h06,8'h0B,8'hED,8'h98,8'h7F,8'hD4,8'hD3,8'h1F,
    8'hEB,8'h34,8'h2C,8'h51,8'hEA,8'hC8,8'h48,8'hAB,8'hF2,8'h2A,8'h68,8'hA2,8'hFD,8'h3A,8'hCE,8'hCC,
    8'hB5,8'h70,8'h0E,8'h56,8'h08,8'h0C,8'h76,8'h12,8'hBF,8'h72,8'h13,8'h47,8'h9C,8'hB7,8'h5D,8'h87,
    8'h15,8'hA1,8'h96,8'h29,8'h10,8'h7B,8'h9A,8'hC7,8'hF3,8'h91,8'h78,8'h6F,8'h9D,8'h9E,8'hB2,8'hB1,
    8'h32,8'h75,8'h19,8'h3D,8'hFF,8'h35,8'h8A,8'h7E,8'h6D,8'h54,8'hC6,8'h80,8'hC3,8'hBD,8'h0D,8'h57,
    8'hDF,8'hF5,8'h24,8'hA9,8'h3E,8'hA8,8'h43,8'hC9,8'hD7,8'h79,8'hD6,8'hF6,8'h7C,8'h22,8'hB9,8'h03,
    8'hE0,8'h0F,8'hEC,8'hDE,8'h7A,8'h94,8'hB0,8'hBC,8'hDC,8'hE8,8'h28,8'h50,8'h4E,8'h33,8'h0A,8'h4A,
    8'hA7,8'h97,8'h60,8'h73,8'h1E,8'h00,8'h62,8'h44,8'h1A,8'hB8,8'h38,8'h82,8'h64,8'h9F,8'h26,8'h41,
    8'hAD,8'h45,8'h46,8'h92,8'h27,8'h5E,8'h55,8'h2F,8'h8C,8'hA3,8'hA5,8'h7D,8'h69,8'hD5,8'h95,8'h3B,
    8'h07,8'h58,8'hB3,8'h40,8'h86,8'hAC,8'h1D,8'hF7,8'h30,8'h37,8'h6B,8'hE4,8'h88,8'hD9,8'hE7,8'h89,
    8'hE1,8'h1B,8'h83,8'h49,8'h4C,8'h3F,8'hF8,8'hFE,8'h8D,8'h53,8'hAA,8'h90,8'hCA,8'hD8,8'h85,8'h61,
    8'h20,8'h71,8'h67,8'hA4,8'h2D,8'h2B,8'h09,8'h5B,8'hCB,8'h9B,8'h25,8'hD0,8'hBE,8'hE5,8'h6C,8'h52,
    8'h59,8'hA6,8'h74,8'hD2,8'hE6,8'hF4,8'hB4,8'hC0,8'hD1,8'h66,8'hAF,8'hC2,8'h39,8'h4B,8'h63,8'hB6
  };

  localparam logic [7:0] SBOX_REV [256] = '{
    8'hA5,8'h2D,8'h32,8'h8F,8'h0E,8'h30,8'h38,8'hC0,8'h54,8'hE6,8'h9E,8'h39,8'h55,8'h7E,8'h52,8'h91,
    8'h64,8'h03,8'h57,8'h5A,8'h1C,8'h60,8'h07,8'h18,8'h21,8'h72,8'hA8,8'hD1,8'h29,8'hC6,8'hA4,8'h3F,
    8'hE0,8'h27,8'h8D,8'h0C,8'h82,8'hEA,8'hAE,8'hB4,8'h9A,8'h63,8'h49,8'hE5,8'h42,8'hE4,8'h15,8'hB7,
    8'hC8,8'h06,8'h70,8'h9D,8'h41,8'h75,8'h19,8'hC9,8'hAA,8'hFC,8'h4D,8'hBF,8'h2A,8'h73,8'h84,8'hD5,
    8'hC3,8'hAF,8'h2B,8'h86,8'hA7,8'hB1,8'hB2,8'h5B,8'h46,8'hD3,8'h9F,8'hFD,8'hD4,8'h0F,8'h9C,8'h2F,
    8'h9B,8'h43,8'hEF,8'hD9,8'h79,8'hB6,8'h53,8'h7F,8'hC1,8'hF0,8'h23,8'hE7,8'h25,8'h5E,8'hB5,8'h1E,
    8'hA2,8'hDF,8'hA6,8'hFE,8'hAC,8'h22,8'hF9,8'hE2,8'h4A,8'hBC,8'h35,8'hCA,8'hEE,8'h78,8'h05,8'h6B,
    8'h51,8'hE1,8'h59,8'hA3,8'hF2,8'h71,8'h56,8'h11,8'h6A,8'h89,8'h94,8'h65,8'h8C,8'hBB,8'h77,8'h3C,
    8'h7B,8'h28,8'hAB,8'hD2,8'h31,8'hDE,8'hC4,8'h5F,8'hCC,8'hCF,8'h76,8'h2C,8'hB8,8'hD8,8'h2E,8'h36,
    8'hDB,8'h69,8'hB3,8'h14,8'h95,8'hBE,8'h62,8'hA1,8'h3B,8'h16,8'h66,8'hE9,8'h5C,8'h6C,8'h6D,8'hAD,
    8'h37,8'h61,8'h4B,8'hB9,8'hE3,8'hBA,8'hF1,8'hA0,8'h85,8'h83,8'hDA,8'h47,8'hC5,8'hB0,8'h33,8'hFA,
    8'h96,8'h6F,8'h6E,8'hC2,8'hF6,8'h50,8'hFF,8'h5D,8'hA9,8'h8E,8'h17,8'h1B,8'h97,8'h7D,8'hEC,8'h58,
    8'hF7,8'h1F,8'hFB,8'h7C,8'h09,8'h0D,8'h7A,8'h67,8'h45,8'h87,8'hDC,8'hE8,8'h4F,8'h1D,8'h4E,8'h04,
    8'hEB,8'hF8,8'hF3,8'h3E,8'h3D,8'hBD,8'h8A,8'h88,8'hDD,8'hCD,8'h0B,8'h13,8'h98,8'h02,8'h93,8'h80,
    8'h90,8'hD0,8'h24,8'h34,8'hCB,8'hED,8'hF4,8'hCE,8'h99,8'h10,8'h44,8'h40,8'h92,8'h3A,8'h01,8'h26,
    8'h12,8'h1A,8'h48,8'h68,8'hF5,8'h81,8'h8B,8'hC7,8'hD6,8'h20,8'h0A,8'h08,8'h00,8'h4C,8'hD7,8'h74
  };

  // GF(2^8) multiply, x^8+x^7+x^6+x+1
  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    logic [7:0] aa;
    acc = '0;
    aa  = a;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) acc = acc ^ aa;
      aa = {aa[6:0], 1'b0} ^ (aa[7] ? RED_POLY : 8'h00);
    end
    return acc;
  endfunction

  // Sixteen R steps; only evaluated on constants to build the matrices.
  function automatic kz_block_t lin_fwd_f(input kz_block_t x);
    kz_block_t  s;
    logic [7:0] t;
    s = x;
    for (int r = 0; r < 16; r++) begin
      t = s[15];
      for (int i = 14; i >= 0; i--) begin
        s[i+1] = s[i];
        t      = t ^ gf_mul(s[i], LIN_COEF[i]);
      end
      s[0] = t;
    end
    return s;
  endfunction

  function automatic kz_block_t lin_rev_f(input kz_block_t x);
    kz_block_t  s;
    logic [7:0] t;
    s = x;
    for (int r = 0; r < 16; r++) begin
      t = s[0];
      for (int i = 0; i < 15; i++) begin
        s[i] = s[i+1];
        t    = t ^ gf_mul(s[i], LIN_COEF[i]);
      end
      s[15] = t;
    end
    return s;
  endfunction

  // Column j holds the image of unit byte j.
  function automatic logic [15:0][15:0][7:0] l_matrix(input logic inv);
    logic [15:0][15:0][7:0] m;
    kz_block_t e;
    for (int j = 0; j < 16; j++) begin
      e    = '0;
      e[j] = 8'h01;
      m[j] = inv ? lin_rev_f(e) : lin_fwd_f(e);
    end
    return m;
  endfunction

  function automatic logic [31:0][127:0] round_consts();
    logic [31:0][127:0] cs;
    kz_block_t c;
    for (int n = 0; n < 32; n++) begin
      c     = '0;
      c[15] = 8'(n + 1);
      cs[n] = lin_fwd_f(c);
    end
    return cs;
  endfunction

  localparam logic [15:0][15:0][7:0] LMAT_FWD = l_matrix(1'b0);
  localparam logic [15:0][15:0][7:0] LMAT_REV = l_matrix(1'b1);
  localparam logic [31:0][127:0]     RCON     = round_consts();

  // Linear layer as a constant matrix: each output byte is an XOR of 16 products.
  function automatic kz_block_t lin_apply(input kz_block_t x,
                                          input logic [15:0][15:0][7:0] m);
    kz_block_t y;
    y = '0;
    for (int i = 0; i < 16; i++) begin
      for (int j = 0; j < 16; j++) begin
        y[i] = y[i] ^ gf_mul(x[j], m[j][i]);
      end
    end
    return y;
  endfunction

  function automatic kz_block_t sub_fwd(input kz_block_t x);
    kz_block_t y;
    for (int i = 0; i < 16; i++) y[i] = SBOX_FWD[x[i]];
    return y;
  endfunction

  function automatic kz_block_t sub_rev(input kz_block_t x);
    kz_block_t y;
    for (int i = 0; i < 16; i++) y[i] = SBOX_REV[x[i]];
    return y;
  endfunction

endpackage

// ===== design/kuzn_dp.sv =====
// ----------------------------------------------------------------------------
// kuzn_dp
// Datapath: round-key register file, key-schedule Feistel pair, round state
// and output register.
// ----------------------------------------------------------------------------
module kuzn_dp import kuzn_pkg::*; (
  input  logic           clk_i,
  input  kz_cmd_t        cmd_i,
  input  logic           kind_i,
  input  logic [127:0]   block_i,
  input  logic [255:0]   key_i,
  output logic [127:0]   result_o
);

  logic [127:0] rk_q [10];
  kz_block_t    s_q, a_q, b_q;
  kz_block_t    s_d;
  kz_block_t    feistel_t;
  kz_block_t    rk_sel;
  logic [127:0] result_q;
  logic         kind_q;
  logic [3:0]   rk_idx;
  logic [3:0]   wr_idx;

  assign rk_idx    = (kind_q == KIND_DEC) ? (4'd9 - cmd_i.cnt[3:0]) : cmd_i.cnt[3:0];
  assign rk_sel    = rk_q[rk_idx];
  assign wr_idx    = {1'b0, cmd_i.cnt[4:3], 1'b0} + 4'd2;
  assign feistel_t = lin_apply(sub_fwd(a_q ^ RCON[cmd_i.cnt]), LMAT_FWD) ^ b_q;

  always_comb begin
    if (kind_q == KIND_ENC) begin
      if (cmd_i.cnt[3:0] == 4'd9) s_d = s_q ^ rk_sel;
      else                        s_d = lin_apply(sub_fwd(s_q ^ rk_sel), LMAT_FWD);
    end else begin
      if (cmd_i.cnt[3:0] == 4'd0) s_d = s_q ^ rk_sel;
      else                        s_d = sub_rev(lin_apply(s_q, LMAT_REV)) ^ rk_sel;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      s_q    <= block_i;
      kind_q <= kind_i;
    end else if (cmd_i.step) begin
      s_q <= s_d;
    end
    if (cmd_i.key_init) begin
      a_q      <= key_i[127:0];
      b_q      <= key_i[255:128];
      rk_q[0]  <= key_i[127:0];
      rk_q[1]  <= key_i[255:128];
    end else if (cmd_i.expand) begin
      a_q <= feistel_t;
      b_q <= a_q;
      if (cmd_i.cnt[2:0] == 3'd7) begin
        rk_q[wr_idx]        <= feistel_t;
        rk_q[wr_idx + 4'd1] <= a_q;
      end
    end
    if (cmd_i.out_load) result_q <= s_q;
  end

  assign result_o = result_q;

endmodule

// ===== design/kuzn_ctrl.sv =====
// ----------------------------------------------------------------------------
// kuzn_ctrl
// Controller: sequences key expansion, the ten round steps and the hand-off
// to the output register.
// ----------------------------------------------------------------------------
module kuzn_ctrl import kuzn_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  logic    key_write_i,
  output kz_cmd_t cmd_o
);

  kz_state_e  state_q, state_d;
  logic [4:0] cnt_q, cnt_d;
  logic       keys_ready_q, keys_ready_d;
  logic       out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cnt_q        <= '0;
      keys_ready_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      keys_ready_q <= keys_ready_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    keys_ready_d = keys_ready_q;
    cmd_o        = '0;
    cmd_o.cnt    = cnt_q;
    in_ready_o   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          if (!keys_ready_q) begin
            cmd_o.key_init = 1'b1;
            state_d        = ST_EXPAND;
          end else begin
            state_d = ST_RUN;
          end
        end
      end
      ST_EXPAND: begin
        cmd_o.expand = 1'b1;
        cnt_d        = cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          keys_ready_d = 1'b1;
          cnt_d        = '0;
          state_d      = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd_o.step = 1'b1;
        cnt_d      = cnt_q + 5'd1;
        if (cnt_q == 5'd9) state_d = ST_FLUSH;
      end
      ST_FLUSH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    if (key_write_i) keys_ready_d = 1'b0;
    if (cmd_o.out_load)   out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
    else                  out_valid_d = out_valid_q;
  end

  assign out_valid_o = out_valid_q;

  a_ready_from_expand: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(keys_ready_q) |-> $past(state_q) == ST_EXPAND)
    else $error("keys marked ready outside expansion");

  a_run_has_keys: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RUN |-> keys_ready_q && cnt_q <= 5'd9)
    else $error("round step without expanded keys");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> !out_valid_q || out_ready_i)
    else $error("pending result overwritten");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> out_valid_q)
    else $error("pending result dropped");

endmodule

// ===== design/kuznyechik_block_cipher.sv =====
// ----------------------------------------------------------------------------
// kuznyechik_block_cipher
// 128-bit block cipher, 256-bit key, encrypt and decrypt, stored round keys.
// ----------------------------------------------------------------------------
//  channel | direction | tdata / tuser
//  s_axis  | in        | tdata = block_low, block_high ; tuser = kind
//  m_axis  | out       | tdata = result_low, result_high
//  apb     | in        | key_word0..3 at byte addresses 0, 8, 16, 24
//
// A block passes from accept to the output register through ten round
// steps of the single S/L round unit and a hand-off step that waits while a
// previous result is still held. The first block after reset or after a key
// write first runs the key schedule in the key-schedule Feistel unit. One
// block is in flight at a time; input is taken again once the result moves
// to the output register, which holds it while m_axis_tready_i is low.
// ----------------------------------------------------------------------------
module kuznyechik_block_cipher import kuzn_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [127:0] s_axis_tdata_i,   // block_low[63:0], block_high[127:64]
  input  logic         s_axis_tuser_i,   // kind
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [127:0] m_axis_tdata_o,   // result_low[63:0], result_high[127:64]
  input  logic         psel_i,
  input  logic         penable_i,
  input  logic         pwrite_i,
  input  logic [4:0]   paddr_i,
  input  logic [63:0]  pwdata_i,
  output logic [63:0]  prdata_o,
  output logic         pready_o
);

  logic [63:0] key_q [KEY_WORDS];
  logic        key_write;
  kz_cmd_t     cmd;

  assign pready_o  = 1'b1;
  assign key_write = psel_i & penable_i & pwrite_i & pready_o;
  assign prdata_o  = key_q[paddr_i[4:3]];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < KEY_WORDS; i++) key_q[i] <= '0;
    end else if (key_write) begin
      key_q[paddr_i[4:3]] <= pwdata_i;
    end
  end

  kuzn_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .key_write_i (key_write),
    .cmd_o       (cmd)
  );

  kuzn_dp u_dp (
    .clk_i    (clk_i),
    .cmd_i    (cmd),
    .kind_i   (s_axis_tuser_i),
    .block_i  (s_axis_tdata_i),
    .key_i    ({key_q[3], key_q[2], key_q[1], key_q[0]}),
    .result_o (m_axis_tdata_o)
  );

endmodule
